/* src/wbbs_pkg.sv */
// Package for the white-blob steering block: widths, Q.14 constants and shared types.
// No dependencies; used by every module of the block.
package wbbs_pkg;

    localparam int COORD_BITS = 12;
    localparam int DIM_W      = 12;
    localparam int FRAC_W     = 15;
    localparam int CMP_W      = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 1;
    localparam int ONE_Q14    = 16384;

    localparam int DIV_DEN_W  = 2 * DIM_W;
    localparam int DIV_NUM_A  = 2 * COORD_BITS + 15;
    localparam int DIV_NUM_W  = (DIV_NUM_A > 30) ? DIV_NUM_A : 30;
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);

    localparam int ADDR_W     = 5;
    localparam logic [2:0] REG_WIDTH    = 3'd0;
    localparam logic [2:0] REG_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_SPEED    = 3'd2;
    localparam logic [2:0] REG_STEER    = 3'd3;
    localparam logic [2:0] REG_STOP     = 3'd4;
    localparam logic [2:0] REG_DEADBAND = 3'd5;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic [DIM_W-1:0]  frame_width;
        logic [DIM_W-1:0]  frame_height;
        logic [FRAC_W-1:0] speed_limit;
        logic [FRAC_W-1:0] steer_limit;
        logic [FRAC_W-1:0] stop_area;
        logic [FRAC_W-1:0] steer_deadband;
    } t_cfg;

    typedef struct packed {
        logic   found;
        t_coord min_col;
        t_coord max_col;
        t_coord min_row;
        t_coord max_row;
    } t_job;

    function automatic logic [DIM_W-1:0] dim_eff(input logic [DIM_W-1:0] d);
        return (d == '0) ? DIM_W'(1) : d;
    endfunction

    function automatic logic [FRAC_W-1:0] stop_eff(input logic [FRAC_W-1:0] d);
        return (d == '0) ? FRAC_W'(1) : d;
    endfunction

endpackage

/* src/wbbs_front.sv */
// Front end: pixel counters, white test and bounding box; emits one job per frame.
// Depends on wbbs_pkg.
module wbbs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wbbs_pkg::t_cfg i_cfg,
    input  logic          i_take,
    input  logic [7:0]    i_red,
    input  logic [7:0]    i_green,
    input  logic [7:0]    i_blue,
    output logic          o_push,
    output wbbs_pkg::t_job o_job
);
    import wbbs_pkg::*;

    t_coord r_col, r_row, r_minc, r_minr, r_maxc, r_maxr;
    logic   r_found;
    t_coord n_minc, n_minr, n_maxc, n_maxr;
    logic   n_found, white, row_end, frame_end;
    logic [CMP_W-1:0] col_nx, row_nx;

    always_comb begin
        white  = (i_red == 8'hFF) && (i_green == 8'hFF) && (i_blue == 8'hFF);
        n_minc = r_minc;
        n_minr = r_minr;
        n_maxc = r_maxc;
        n_maxr = r_maxr;
        n_found = r_found;
        if (white) begin
            n_found = 1'b1;
            if (r_col < r_minc) n_minc = r_col;
            if (r_row < r_minr) n_minr = r_row;
            if (r_col > r_maxc) n_maxc = r_col;
            if (r_row > r_maxr) n_maxr = r_row;
        end
        col_nx    = CMP_W'(r_col) + CMP_W'(1);
        row_nx    = CMP_W'(r_row) + CMP_W'(1);
        row_end   = col_nx >= CMP_W'(dim_eff(i_cfg.frame_width));
        frame_end = row_end && (row_nx >= CMP_W'(dim_eff(i_cfg.frame_height)));
        o_push    = i_take && frame_end;
        o_job     = '{found: n_found, min_col: n_minc, max_col: n_maxc,
                      min_row: n_minr, max_row: n_maxr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_col   <= '0;
            r_row   <= '0;
            r_minc  <= '1;
            r_minr  <= '1;
            r_maxc  <= '0;
            r_maxr  <= '0;
            r_found <= 1'b0;
        end else if (i_take) begin
            r_minc  <= n_minc;
            r_minr  <= n_minr;
            r_maxc  <= n_maxc;
            r_maxr  <= n_maxr;
            r_found <= n_found;
            if (row_end) begin
                r_col <= '0;
                r_row <= row_nx[COORD_BITS-1:0];
            end else begin
                r_col <= col_nx[COORD_BITS-1:0];
            end
        end
    end

endmodule

/* src/wbbs_queue.sv */
// Two-entry job queue between the pixel front end and the drive back end.
// Depends on wbbs_pkg.
module wbbs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wbbs_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output wbbs_pkg::t_job o_job
);
    import wbbs_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

/* src/wbbs_div.sv */
// Restoring divider, one quotient bit per cycle, shared by the back end.
// Depends on wbbs_pkg.
module wbbs_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [wbbs_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [wbbs_pkg::DIV_DEN_W-1:0] i_den,
    output logic                          o_done,
    output logic [wbbs_pkg::DIV_NUM_W-1:0] o_quo
);
    import wbbs_pkg::*;

    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W:0]   r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy, r_done;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    always_comb begin
        trial = {r_rem[DIV_DEN_W-1:0], r_quo[DIV_NUM_W-1]};
        fits  = trial >= {1'b0, r_den};
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_den}) : trial;
            r_quo <= {r_quo[DIV_NUM_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

/* src/wbbs_back.sv */
// Back end: per-frame steer and speed sequencer with output register.
// Depends on wbbs_pkg and wbbs_div.
module wbbs_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wbbs_pkg::t_cfg       i_cfg,
    input  logic                 i_have,
    input  wbbs_pkg::t_job       i_job,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [14:0]          o_speed,
    output logic signed [15:0]   o_steer,
    output logic                 o_ball_seen
);
    import wbbs_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_QGO   = 4'd1;
    localparam logic [3:0] ST_QWAIT = 4'd2;
    localparam logic [3:0] ST_MUL1  = 4'd3;
    localparam logic [3:0] ST_AGO   = 4'd4;
    localparam logic [3:0] ST_AWAIT = 4'd5;
    localparam logic [3:0] ST_DGO   = 4'd6;
    localparam logic [3:0] ST_DWAIT = 4'd7;
    localparam logic [3:0] ST_MUL2  = 4'd8;
    localparam logic [3:0] ST_MUL3  = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [3:0]           r_st;
    t_job                 r_job;
    logic [FRAC_W-1:0]    r_mag, r_a, r_dist, r_speed;
    logic                 r_neg, r_seen;
    logic signed [15:0]   r_steer;
    logic [29:0]          r_psteer, r_p1;
    logic [DIV_DEN_W-1:0] r_parea, r_wh;
    logic                 r_ov;
    logic [14:0]          r_os;
    logic signed [15:0]   r_ot;
    logic                 r_ob;

    logic                 div_start, div_done;
    logic [DIV_NUM_W-1:0] div_num, div_quo;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIM_W-1:0]     w_e;
    logic [FRAC_W-1:0]    s_e;
    logic [COORD_BITS:0]  sum;
    logic [15:0]          q_sat;
    logic signed [16:0]   s_val;
    logic [16:0]          s_abs;
    logic [16:0]          v_st;
    logic [44:0]          p_sp;
    logic [17:0]          v_sp;
    t_coord               dc, dr;
    logic                 out_free;

    wbbs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        w_e   = dim_eff(i_cfg.frame_width);
        s_e   = stop_eff(i_cfg.stop_area);
        sum   = (COORD_BITS+1)'(r_job.min_col) + (COORD_BITS+1)'(r_job.max_col);
        dc    = (r_job.max_col >= r_job.min_col) ? r_job.max_col - r_job.min_col : '0;
        dr    = (r_job.max_row >= r_job.min_row) ? r_job.max_row - r_job.min_row : '0;
        q_sat = (div_quo > DIV_NUM_W'(2 * ONE_Q14)) ? 16'(2 * ONE_Q14) : div_quo[15:0];
        s_val = 17'sd16384 - $signed({1'b0, q_sat});
        s_abs = s_val[16] ? 17'(-s_val) : 17'(s_val);
        v_st  = 17'((31'(r_psteer) + 31'd8192) >> 14);
        p_sp  = 45'(r_p1) * 45'(15'(ONE_Q14) - r_mag);
        v_sp  = 18'((46'(p_sp) + 46'(1) * (46'd1 << 27)) >> 28);
        out_free = !r_ov || !i_stall;

        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (r_st)
            ST_QGO: begin
                div_start = 1'b1;
                div_num   = (DIV_NUM_W'(sum) << 14) + DIV_NUM_W'(w_e >> 1);
                div_den   = DIV_DEN_W'(w_e);
            end
            ST_AGO: begin
                div_start = 1'b1;
                div_num   = (DIV_NUM_W'(r_parea) << 14) + DIV_NUM_W'(r_wh >> 1);
                div_den   = r_wh;
            end
            ST_DGO: begin
                div_start = 1'b1;
                div_num   = (DIV_NUM_W'(r_a) << 14) + DIV_NUM_W'(s_e >> 1);
                div_den   = DIV_DEN_W'(s_e);
            end
            default: ;
        endcase
        o_pop = (r_st == ST_IDLE) && i_have;
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: begin
                r_job   <= i_job;
                r_speed <= '0;
                r_steer <= '0;
                r_seen  <= i_job.found;
            end
            ST_QWAIT: begin
                if (s_abs < 17'(i_cfg.steer_deadband)) begin
                    r_mag <= '0;
                    r_neg <= 1'b0;
                end else begin
                    r_mag <= s_abs[FRAC_W-1:0];
                    r_neg <= s_val[16];
                end
            end
            ST_MUL1: begin
                r_psteer <= 30'(i_cfg.steer_limit) * 30'(r_mag);
                r_parea  <= DIV_DEN_W'(dc) * DIV_DEN_W'(dr);
                r_wh     <= DIV_DEN_W'(w_e) * DIV_DEN_W'(dim_eff(i_cfg.frame_height));
            end
            ST_AGO: begin
                if (v_st > 17'(ONE_Q14))
                    r_steer <= r_neg ? -16'sd16384 : 16'sd16384;
                else
                    r_steer <= r_neg ? -$signed(16'(v_st)) : $signed(16'(v_st));
            end
            ST_AWAIT: begin
                r_a <= (div_quo > DIV_NUM_W'(s_e)) ? s_e : div_quo[FRAC_W-1:0];
            end
            ST_DWAIT: r_dist <= 15'(ONE_Q14) - div_quo[FRAC_W-1:0];
            ST_MUL2:  r_p1 <= 30'(i_cfg.speed_limit) * 30'(r_dist);
            ST_MUL3:  r_speed <= (v_sp > 18'(ONE_Q14)) ? 15'(ONE_Q14) : v_sp[14:0];
            default: ;
        endcase
        if (r_st == ST_OUT && out_free) begin
            r_os <= r_speed;
            r_ot <= r_steer;
            r_ob <= r_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_ov <= (r_ov && i_stall) || (r_st == ST_OUT && out_free);
            unique case (r_st)
                ST_IDLE:  if (i_have) r_st <= i_job.found ? ST_QGO : ST_OUT;
                ST_QGO:   r_st <= ST_QWAIT;
                ST_QWAIT: if (div_done) r_st <= ST_MUL1;
                ST_MUL1:  r_st <= ST_AGO;
                ST_AGO:   r_st <= ST_AWAIT;
                ST_AWAIT: if (div_done) r_st <= ST_DGO;
                ST_DGO:   r_st <= ST_DWAIT;
                ST_DWAIT: if (div_done) r_st <= ST_MUL2;
                ST_MUL2:  r_st <= ST_MUL3;
                ST_MUL3:  r_st <= ST_OUT;
                ST_OUT:   if (out_free) r_st <= ST_IDLE;
                default:  r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_valid     = r_ov;
    assign o_speed     = r_os;
    assign o_steer     = r_ot;
    assign o_ball_seen = r_ob;

endmodule

/* src/white_blob_box_steering.sv */
// Top level of the white-blob steering block: APB registers, front end, queue, back end.
// Depends on wbbs_pkg, wbbs_front, wbbs_queue and wbbs_back.
//
// Takes one RGB pixel word per clock in raster order and tracks the bounding box of
// pure white pixels; at the last pixel of each frame one job is queued for the back
// end, which turns it into one result word (speed, steer, ball_seen). Pixels are
// accepted every cycle while the two-entry job queue has room. For a frame with a
// white pixel the back end makes three passes of the bit-serial divider, one quotient
// bit per cycle, plus its multiply and output states; a stalled result word holds it,
// so the pixel input stalls only when the job queue fills. Registers are to be written
// through the APB port only while idle, which the user must ensure; the block does not check it.
module white_blob_box_steering (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_red,
    input  logic [7:0]           i_green,
    input  logic [7:0]           i_blue,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [14:0]          o_speed,
    output logic signed [15:0]   o_steer,
    output logic                 o_ball_seen,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [wbbs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import wbbs_pkg::*;

    t_cfg       r_cfg;
    logic       wr, take, push, pop, full, empty;
    logic [2:0] idx;
    t_job       job_in, job_out;

    assign pready  = 1'b1;
    assign idx     = paddr[4:2];
    assign wr      = psel && penable && pwrite;
    assign o_stall = full;
    assign take    = i_valid && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{frame_width: 12'd640, frame_height: 12'd480, speed_limit: 15'd8192,
                       steer_limit: 15'd8192, stop_area: 15'd1638, steer_deadband: 15'd164};
        end else if (wr) begin
            unique case (idx)
                REG_WIDTH:    r_cfg.frame_width    <= pwdata[DIM_W-1:0];
                REG_HEIGHT:   r_cfg.frame_height   <= pwdata[DIM_W-1:0];
                REG_SPEED:    r_cfg.speed_limit    <= pwdata[FRAC_W-1:0];
                REG_STEER:    r_cfg.steer_limit    <= pwdata[FRAC_W-1:0];
                REG_STOP:     r_cfg.stop_area      <= pwdata[FRAC_W-1:0];
                REG_DEADBAND: r_cfg.steer_deadband <= pwdata[FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_WIDTH:    prdata = 32'(r_cfg.frame_width);
            REG_HEIGHT:   prdata = 32'(r_cfg.frame_height);
            REG_SPEED:    prdata = 32'(r_cfg.speed_limit);
            REG_STEER:    prdata = 32'(r_cfg.steer_limit);
            REG_STOP:     prdata = 32'(r_cfg.stop_area);
            REG_DEADBAND: prdata = 32'(r_cfg.steer_deadband);
            default:      prdata = '0;
        endcase
    end

    wbbs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_take  (take),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_push  (push),
        .o_job   (job_in)
    );

    wbbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_job   (job_out)
    );

    wbbs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_have      (!empty),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_speed     (o_speed),
        .o_steer     (o_steer),
        .o_ball_seen (o_ball_seen)
    );

endmodule

/* src/wbbs_checker.sv */
// Port-level checker for the white-blob steering block, bound to the top level.
// Depends on wbbs_pkg and white_blob_box_steering.
module wbbs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic [14:0]        o_speed,
    input logic signed [15:0] o_steer,
    input logic               o_ball_seen,
    input logic               pready
);
    import wbbs_pkg::*;

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("result word valid straight after reset");

    a_no_ball_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ball_seen) |-> (o_speed == '0 && o_steer == '0))
        else $error("non-zero drive without a ball");

    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_speed <= 15'd16384 && o_steer <= 16'sd16384 && o_steer >= -16'sd16384))
        else $error("drive word out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_speed) && $stable(o_steer)))
        else $error("stalled result word changed");

    a_pready: assert property (@(posedge i_clk) pready) else $error("pready low");

endmodule

bind white_blob_box_steering wbbs_checker u_wbbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_speed     (o_speed),
    .o_steer     (o_steer),
    .o_ball_seen (o_ball_seen),
    .pready      (pready)
);
